// ===== sv/dts_pkg.sv =====
// Shared types and constants for the display text scroller.
// Used by dts_step, display_text_scroller, dts_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package dts_pkg;

	localparam int unsigned SizeW   = 16;
	localparam int unsigned SpeedW  = 12;
	localparam int unsigned PauseW  = 16;
	localparam int unsigned ModeW   = 2;
	localparam int unsigned OffsetW = 17;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned InW     = 40;
	localparam int unsigned OutW    = 24;

	localparam logic [ModeW-1:0] MODE_OFF    = 2'd0;
	localparam logic [ModeW-1:0] MODE_LOOP   = 2'd1;
	localparam logic [ModeW-1:0] MODE_BOUNCE = 2'd2;

	localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_SPEED  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_PAUSE  = 2'd2;

	localparam logic [SpeedW-1:0] SPEED_RESET = 12'd16;

	// Status codes double as the scroll phase codes.
	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_PAUSED   = 3'd1,
		ST_STAGE1   = 3'd2,
		ST_STAGE2   = 3'd3,
		ST_FINISHED = 3'd4
	} status_t;

	typedef struct packed {
		logic [SizeW-1:0]  offset;     // magnitude; the shown offset is its negation
		status_t           phase;
		status_t           phase_prev;
		logic              pausing;
		logic [PauseW-1:0] delay;
	} scroll_state_t;

	localparam scroll_state_t STATE_RESET = '{
		offset:     '0,
		phase:      ST_NONE,
		phase_prev: ST_NONE,
		pausing:    1'b0,
		delay:      '0
	};

endpackage

// ===== sv/dts_step.sv =====
// Next-state and status logic for one scroller update.
// Purely combinational; uses types and constants from dts_pkg.
`timescale 1ns / 1ps

module dts_step (
	input  logic [dts_pkg::ModeW-1:0]  mode,
	input  logic [dts_pkg::SpeedW-1:0] speed,
	input  logic [dts_pkg::PauseW-1:0] pause_length,
	input  logic [dts_pkg::SizeW-1:0]  object_size,
	input  logic [dts_pkg::SizeW-1:0]  canvas_size,
	input  logic                       hold,
	input  dts_pkg::scroll_state_t     cur_state,
	output dts_pkg::scroll_state_t     nxt_state,
	output dts_pkg::status_t           status
);

	always_comb begin
		logic [dts_pkg::SizeW:0]   sum;
		logic [dts_pkg::SizeW-1:0] diff;
		dts_pkg::status_t          cur;
		dts_pkg::status_t          nxt;
		logic                      held;

		nxt_state = cur_state;
		status    = dts_pkg::ST_NONE;
		sum       = {1'b0, cur_state.offset} + {{(dts_pkg::SizeW + 1 - dts_pkg::SpeedW){1'b0}}, speed};
		diff      = object_size - canvas_size;
		cur       = cur_state.phase;
		nxt       = cur;
		held      = 1'b0;

		if (canvas_size > object_size || (mode != dts_pkg::MODE_LOOP &&
				mode != dts_pkg::MODE_BOUNCE) || speed == '0) begin
			status = dts_pkg::ST_NONE;
		end else if (hold) begin
			status = dts_pkg::ST_PAUSED;
		end else if (cur_state.pausing && cur_state.delay != '0) begin
			// count down an end hold
			nxt_state.delay = cur_state.delay - 1'b1;
			status          = dts_pkg::ST_PAUSED;
		end else begin
			nxt_state.pausing = 1'b0;
			nxt_state.delay   = '0;
			case (cur)
				dts_pkg::ST_FINISHED: begin
					nxt_state.offset = '0;
					nxt = dts_pkg::ST_STAGE1;
					if (pause_length != '0) begin
						nxt_state.pausing = 1'b1;
						nxt_state.delay   = pause_length;
					end
				end
				dts_pkg::ST_STAGE1: begin
					if (mode == dts_pkg::MODE_LOOP) begin
						// stage test uses the unsaturated sum
						if (sum > {1'b0, diff})
							nxt = dts_pkg::ST_STAGE2;
						nxt_state.offset = (sum > {1'b0, object_size}) ? object_size
							: sum[dts_pkg::SizeW-1:0];
					end else begin
						if (sum >= {1'b0, diff}) begin
							nxt_state.offset = diff;
							nxt = dts_pkg::ST_STAGE2;
						end else begin
							nxt_state.offset = sum[dts_pkg::SizeW-1:0];
						end
					end
				end
				dts_pkg::ST_STAGE2: begin
					if (mode == dts_pkg::MODE_LOOP) begin
						if (sum >= {1'b0, object_size}) begin
							nxt_state.offset = object_size;
							nxt = dts_pkg::ST_FINISHED;
						end else begin
							nxt_state.offset = sum[dts_pkg::SizeW-1:0];
						end
					end else begin
						// on the first step back, hold at the far edge if a pause length is set
						if (cur_state.phase_prev == dts_pkg::ST_STAGE1 && pause_length != '0) begin
							held              = 1'b1;
							nxt_state.pausing = 1'b1;
							nxt_state.delay   = pause_length;
						end
						if (!held) begin
							if ({{(dts_pkg::SizeW - dts_pkg::SpeedW){1'b0}}, speed} >=
									cur_state.offset) begin
								nxt_state.offset = '0;
								nxt = dts_pkg::ST_FINISHED;
							end else begin
								nxt_state.offset = cur_state.offset -
									{{(dts_pkg::SizeW - dts_pkg::SpeedW){1'b0}}, speed};
							end
						end
					end
				end
				default: begin
					// idle turns into stage one without moving
					cur = dts_pkg::ST_STAGE1;
					nxt = dts_pkg::ST_STAGE1;
				end
			endcase
			nxt_state.phase_prev = cur;
			nxt_state.phase      = nxt;
			status               = cur;
		end
	end

endmodule

// ===== sv/display_text_scroller.sv =====
// Top level of the display text scroller: input register, scroll state,
// result register and configuration registers. Depends on dts_pkg, dts_step.
`timescale 1ns / 1ps

//  channel   direction  fields (low bit up)
//  s_*       in         object_size[15:0], canvas_size[31:16], hold[32], zero pad
//  m_*       out        status[2:0], offset[19:3], zero pad
//  cfg_*     in         0 mode, 1 speed, 2 pause_length
//
//  One item per cycle while m_tready is high; each item passes the input
//  register, then the result register.
//  The scroll state updates as an item moves from the input register to the
//  result register, so consecutive items see each other's state directly.
//  Reset clears both valid flags and the scroll state and sets the config registers to their reset values.
//  With m_tready low the result holds; s_tready drops once the input register
//  is also full.

module display_text_scroller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [dts_pkg::InW-1:0]     s_tdata,   // object_size, canvas_size, hold
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [dts_pkg::OutW-1:0]    m_tdata,   // status, offset
	input  logic                        cfg_we,
	input  logic [dts_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [dts_pkg::CfgW-1:0]    cfg_data
);

	logic [dts_pkg::ModeW-1:0]  mode_q;
	logic [dts_pkg::SpeedW-1:0] speed_q;
	logic [dts_pkg::PauseW-1:0] pause_length_q;

	logic                       valid_s1;
	logic [dts_pkg::SizeW-1:0]  object_size_s1;
	logic [dts_pkg::SizeW-1:0]  canvas_size_s1;
	logic                       hold_s1;

	dts_pkg::scroll_state_t     state_q;
	dts_pkg::scroll_state_t     state_nxt;
	dts_pkg::status_t           status_nxt;

	logic                       valid_s2;
	dts_pkg::status_t           status_s2;
	logic [dts_pkg::OffsetW-1:0] offset_s2;

	logic                       advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= dts_pkg::MODE_OFF;
			speed_q        <= dts_pkg::SPEED_RESET;
			pause_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dts_pkg::CFG_MODE:  mode_q         <= cfg_data[dts_pkg::ModeW-1:0];
				dts_pkg::CFG_SPEED: speed_q        <= cfg_data[dts_pkg::SpeedW-1:0];
				dts_pkg::CFG_PAUSE: pause_length_q <= cfg_data[dts_pkg::PauseW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			object_size_s1 <= s_tdata[dts_pkg::SizeW-1:0];
			canvas_size_s1 <= s_tdata[2*dts_pkg::SizeW-1:dts_pkg::SizeW];
			hold_s1        <= s_tdata[2*dts_pkg::SizeW];
		end
	end

	dts_step u_step (
		.mode         (mode_q),
		.speed        (speed_q),
		.pause_length (pause_length_q),
		.object_size  (object_size_s1),
		.canvas_size  (canvas_size_s1),
		.hold         (hold_s1),
		.cur_state    (state_q),
		.nxt_state    (state_nxt),
		.status       (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dts_pkg::STATE_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_nxt;
			offset_s2 <= '0 - {1'b0, state_nxt.offset};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(dts_pkg::OutW - dts_pkg::OffsetW - 3){1'b0}}, offset_s2, status_s2};

endmodule

// ===== sv/dts_checker.sv =====
// Port-level checks for display_text_scroller, attached by bind.
// Depends on dts_pkg for port widths.
`timescale 1ns / 1ps

module dts_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [dts_pkg::OutW-1:0]    m_tdata
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// offset is never above zero
	a_offset_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19] || m_tdata[19:3] == 17'd0))
		else $error("positive scroll offset");

	// status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= 3'd4))
		else $error("undefined status code");

	// with no result waiting, an input slot is always open
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind display_text_scroller dts_checker u_dts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for display_text_scroller: stream driver, stream monitor
// and a cycle-free scroll predictor kept in step with the register writes.
// Depends on dts_pkg and the display_text_scroller RTL only.
`timescale 1ns / 1ps

module testbench;

	localparam logic [dts_pkg::ModeW-1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned TARGET_UPDATES = 1650;
	localparam int unsigned MAX_ERR_REPORT = 10;

	typedef struct {
		bit                          is_write;
		logic [dts_pkg::CfgIdxW-1:0] reg_index;
		logic [dts_pkg::CfgW-1:0]    reg_value;
		logic [dts_pkg::SizeW-1:0]   obj_size;
		logic [dts_pkg::SizeW-1:0]   can_size;
		logic                        usr_hold;
	} update_t;

	typedef struct {
		dts_pkg::status_t            status;
		logic [dts_pkg::OffsetW-1:0] offset;
	} scroll_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [dts_pkg::InW-1:0] s_tdata = '0;       // object_size, canvas_size, hold, zero pad
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [dts_pkg::OutW-1:0] m_tdata;           // status, offset, zero pad
	logic cfg_we = 1'b0;
	logic [dts_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [dts_pkg::CfgW-1:0] cfg_data = '0;

	update_t     update_q[$];
	scroll_out_t scroll_out_q[$];

	// predictor copy of the registers and of the scroll state
	logic [dts_pkg::ModeW-1:0] scroll_mode = dts_pkg::MODE_OFF;
	int unsigned       scroll_speed = dts_pkg::SPEED_RESET;
	int unsigned       scroll_pause = 0;
	int unsigned       scroll_mag = 0;
	dts_pkg::status_t  phase = dts_pkg::ST_NONE;
	dts_pkg::status_t  phase_prev = dts_pkg::ST_NONE;
	bit                end_hold_on = 1'b0;
	int unsigned       end_hold_left = 0;

	// driver state
	update_t     on_bus;
	bit          next_valid;
	bit          next_we;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned quiet_cycles = 0;

	// receiver stall pattern
	int unsigned stall_kind = 0;
	int unsigned stall_left = 0;
	bit          next_ready;

	int unsigned mismatches = 0;
	int unsigned updates_taken = 0;
	int unsigned writes_done = 0;
	int unsigned results_checked = 0;
	int unsigned status_seen[5] = '{default: 0};

	display_text_scroller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_ERR_REPORT) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	function automatic void start_end_hold();
		if (scroll_pause != 0) begin
			end_hold_on = 1'b1;
			end_hold_left = scroll_pause;
		end
	endfunction

	function automatic void apply_setting(input logic [dts_pkg::CfgIdxW-1:0] idx,
			input logic [dts_pkg::CfgW-1:0] value);
		case (idx)
			dts_pkg::CFG_MODE:  scroll_mode = value[dts_pkg::ModeW-1:0];
			dts_pkg::CFG_SPEED: scroll_speed = value[dts_pkg::SpeedW-1:0];
			dts_pkg::CFG_PAUSE: scroll_pause = value[dts_pkg::PauseW-1:0];
			default: ;
		endcase
	endfunction

	// One update of the scroller: returns the status and the shown offset.
	function automatic scroll_out_t predict_scroll(input logic [dts_pkg::SizeW-1:0] obj_size,
			input logic [dts_pkg::SizeW-1:0] can_size, input logic usr_hold);
		scroll_out_t res;
		int unsigned o;
		int unsigned c;
		int unsigned span;
		int unsigned total;
		dts_pkg::status_t cur;
		dts_pkg::status_t nxt;
		bit held;
		o = obj_size;
		c = can_size;
		res.status = dts_pkg::ST_NONE;
		if (c > o || !(scroll_mode == dts_pkg::MODE_LOOP || scroll_mode == dts_pkg::MODE_BOUNCE)
				|| scroll_speed == 0) begin
			res.status = dts_pkg::ST_NONE;
		end else if (usr_hold) begin
			res.status = dts_pkg::ST_PAUSED;
		end else if (end_hold_on && end_hold_left != 0) begin
			end_hold_left--;
			res.status = dts_pkg::ST_PAUSED;
		end else begin
			end_hold_on = 1'b0;
			end_hold_left = 0;
			cur = phase;
			nxt = cur;
			span = o - c;
			case (cur)
				dts_pkg::ST_FINISHED: begin
					scroll_mag = 0;
					nxt = dts_pkg::ST_STAGE1;
					start_end_hold();
				end
				dts_pkg::ST_STAGE1: begin
					total = scroll_mag + scroll_speed;
					if (scroll_mode == dts_pkg::MODE_LOOP) begin
						// stage test on the raw sum, offset clamps at the object width
						if (total > span) nxt = dts_pkg::ST_STAGE2;
						scroll_mag = (total > o) ? o : total;
					end else if (total >= span) begin
						scroll_mag = span;
						nxt = dts_pkg::ST_STAGE2;
					end else begin
						scroll_mag = total;
					end
				end
				dts_pkg::ST_STAGE2: begin
					if (scroll_mode == dts_pkg::MODE_LOOP) begin
						total = scroll_mag + scroll_speed;
						if (total >= o) begin
							scroll_mag = o;
							nxt = dts_pkg::ST_FINISHED;
						end else begin
							scroll_mag = total;
						end
					end else begin
						held = 1'b0;
						// first step at the far edge may start the end hold instead of moving
						if (phase_prev == dts_pkg::ST_STAGE1) begin
							start_end_hold();
							held = end_hold_on;
						end
						if (!held) begin
							if (scroll_speed >= scroll_mag) begin
								scroll_mag = 0;
								nxt = dts_pkg::ST_FINISHED;
							end else begin
								scroll_mag = scroll_mag - scroll_speed;
							end
						end
					end
				end
				default: begin
					cur = dts_pkg::ST_STAGE1;
					nxt = dts_pkg::ST_STAGE1;
				end
			endcase
			phase_prev = cur;
			phase = nxt;
			res.status = cur;
		end
		res.offset = dts_pkg::OffsetW'(32'd0 - scroll_mag);
		return res;
	endfunction

	// Driver: present items in bursts, hold register writes until the block is quiet.
	always @(posedge clk) begin
		if (arst_n) begin
			next_valid = s_tvalid;
			next_we = 1'b0;
			if (s_tvalid && s_tready) begin
				scroll_out_q.push_back(predict_scroll(on_bus.obj_size, on_bus.can_size,
					on_bus.usr_hold));
				updates_taken++;
				next_valid = 1'b0;
			end
			if (!next_valid && update_q.size() != 0) begin
				if (update_q[0].is_write) begin
					if (quiet_cycles >= SETTLE_CYCLES) begin
						next_we = 1'b1;
						cfg_index <= update_q[0].reg_index;
						cfg_data <= update_q[0].reg_value;
						apply_setting(update_q[0].reg_index, update_q[0].reg_value);
						writes_done++;
						void'(update_q.pop_front());
					end
				end else if (gap_left != 0) begin
					gap_left--;
				end else begin
					on_bus = update_q.pop_front();
					s_tdata <= {7'b0, on_bus.usr_hold, on_bus.can_size, on_bus.obj_size};
					next_valid = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						if ($urandom_range(0, 3) == 0) begin
							burst_left = $urandom_range(30, 80);
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 12);
							gap_left = $urandom_range(0, 6);
						end
					end
				end
			end
			if (!next_valid && !s_tvalid && !next_we && scroll_out_q.size() == 0) begin
				quiet_cycles++;
			end else begin
				quiet_cycles = 0;
			end
			s_tvalid <= next_valid;
			cfg_we <= next_we;
		end
	end

	// Monitor: check each accepted result against the oldest prediction.
	always @(posedge clk) begin
		scroll_out_t want;
		logic [dts_pkg::OffsetW-1:0] got_offset;
		logic [2:0] got_status;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_status = m_tdata[2:0];
				got_offset = m_tdata[3 +: dts_pkg::OffsetW];
				if (scroll_out_q.size() == 0) begin
					flag_error($sformatf("unexpected result status %0d offset %0d",
						got_status, $signed(got_offset)));
				end else begin
					want = scroll_out_q.pop_front();
					results_checked++;
					status_seen[want.status]++;
					if (got_status != want.status) begin
						flag_error($sformatf("status: expected %0d (%s), got %0d",
							want.status, want.status.name(), got_status));
					end
					if (got_offset != want.offset) begin
						flag_error($sformatf("offset: expected %0d, got %0d",
							$signed(want.offset), $signed(got_offset)));
					end
				end
			end
			if (stall_left == 0) begin
				stall_kind = $urandom_range(0, 3);
				stall_left = $urandom_range(10, 60);
			end
			stall_left--;
			case (stall_kind)
				0:       next_ready = 1'b1;
				1:       next_ready = ($urandom_range(0, 1) == 0);
				2:       next_ready = ($urandom_range(0, 3) == 0);
				default: next_ready = ($urandom_range(0, 7) != 0);
			endcase
			m_tready <= next_ready;
		end
	end

	task automatic add_setting(input logic [dts_pkg::CfgIdxW-1:0] idx,
			input int unsigned value);
		update_t u;
		u = '{is_write: 1'b1, reg_index: idx, reg_value: dts_pkg::CfgW'(value),
			obj_size: '0, can_size: '0, usr_hold: 1'b0};
		update_q.push_back(u);
	endtask

	task automatic add_update(input int unsigned obj_size, input int unsigned can_size,
			input bit usr_hold);
		update_t u;
		u = '{is_write: 1'b0, reg_index: '0, reg_value: '0,
			obj_size: dts_pkg::SizeW'(obj_size), can_size: dts_pkg::SizeW'(can_size),
			usr_hold: usr_hold};
		update_q.push_back(u);
	endtask

	initial begin
		int unsigned live;
		int unsigned run_len;
		int unsigned pick;
		int unsigned speed_val;
		int unsigned span;
		int unsigned base_obj;
		int unsigned base_can;
		int unsigned o;
		int unsigned c;
		int unsigned drain;
		bit h;
		logic [dts_pkg::ModeW-1:0] mode_val;

		// directed: extremes, every mode, the special cases
		add_update(16'hFFFF, 16'h0000, 1'b0);       // scrolling off after reset
		add_setting(dts_pkg::CFG_MODE, dts_pkg::MODE_LOOP);
		add_setting(dts_pkg::CFG_SPEED, 4095);
		add_setting(dts_pkg::CFG_PAUSE, 0);
		add_update(16'h0000, 16'h0001, 1'b0);       // canvas wider than object
		add_update(16'hFFFF, 16'hFFFF, 1'b1);       // user hold
		add_update(16'hFFFF, 16'hFFFF, 1'b0);       // idle turns into stage one
		add_update(16'hFFFF, 16'hFFFF, 1'b0);       // raw sum passes a zero span
		add_update(16'h1000, 16'h0000, 1'b0);       // loop end, offset clamps
		add_update(16'h1000, 16'h0000, 1'b0);
		add_update(16'h1000, 16'h0FFF, 1'b0);
		add_update(16'h1000, 16'h0FFF, 1'b0);
		add_setting(dts_pkg::CFG_SPEED, 0);
		add_update(16'hFFFF, 16'h0000, 1'b0);       // speed zero
		add_setting(dts_pkg::CFG_MODE, MODE_UNUSED);
		add_setting(dts_pkg::CFG_SPEED, 8);
		add_update(16'h0040, 16'h0000, 1'b0);       // unused mode acts as off
		add_setting(dts_pkg::CFG_MODE, dts_pkg::MODE_BOUNCE);
		add_setting(dts_pkg::CFG_PAUSE, 2);
		repeat (11) add_update(16'h0030, 16'h0020, 1'b0);  // full bounce with end holds
		add_setting(dts_pkg::CFG_MODE, dts_pkg::MODE_OFF);
		add_setting(dts_pkg::CFG_PAUSE, 16'hFFFF);
		add_update(16'h8000, 16'h7FFF, 1'b1);

		// random phases: mostly steady scenes so whole scroll cycles play out
		live = 0;
		while (live < TARGET_UPDATES) begin
			pick = $urandom_range(0, 19);
			mode_val = (pick < 8) ? dts_pkg::MODE_LOOP : (pick < 16) ? dts_pkg::MODE_BOUNCE :
				(pick < 18) ? dts_pkg::MODE_OFF : MODE_UNUSED;
			pick = $urandom_range(0, 19);
			speed_val = (pick == 0) ? 0 : (pick < 9) ? $urandom_range(1, 16) :
				(pick < 17) ? $urandom_range(17, 4095) : 4095;
			add_setting(dts_pkg::CFG_MODE, mode_val);
			add_setting(dts_pkg::CFG_SPEED, speed_val);
			pick = $urandom_range(0, 19);
			add_setting(dts_pkg::CFG_PAUSE, (pick < 12) ? 0 :
				(pick < 19) ? $urandom_range(1, 4) : $urandom_range(5, 40));
			run_len = $urandom_range(30, 90);
			base_obj = 0;
			base_can = 0;
			for (int i = 0; i < run_len; i++) begin
				pick = $urandom_range(0, 99);
				if (i == 0 || (pick >= 80 && pick < 88)) begin
					// new scene at most 24 steps wide at this speed
					span = (speed_val == 0) ? 256 : speed_val * $urandom_range(2, 24);
					if (span > 65535) span = 65535;
					base_obj = $urandom_range(0, span);
					base_can = base_obj - $urandom_range(0, base_obj);
				end
				o = base_obj;
				c = base_can;
				h = ($urandom_range(0, 19) == 0);
				if (pick >= 88 && pick < 94) begin
					o = $urandom_range(0, 65535);
					c = $urandom_range(0, 65535);
					h = $urandom_range(0, 1);
				end else if (pick >= 94) begin
					c = o + $urandom_range(1, 64);
					if (c > 65535) begin
						o = 65534;
						c = 65535;
					end
				end
				add_update(o, c, h);
				live++;
			end
		end

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (update_q.size() != 0 || s_tvalid) @(posedge clk);
		drain = 0;
		while (scroll_out_q.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		if (scroll_out_q.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", scroll_out_q.size()));
		end
		repeat (20) @(posedge clk);

		$display("Run covered %0d updates and %0d register writes; %0d results checked.",
			updates_taken, writes_done, results_checked);
		$display("Statuses: none %0d, paused %0d, stage one %0d, stage two %0d, finished %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/dts_pkg.sv
sv/dts_step.sv
sv/display_text_scroller.sv
sv/dts_checker.sv
sim/testbench.sv
